// ----- hdl/vslg_pkg.sv -----
package vslg_pkg;

    localparam int unsigned CMD_W   = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PULSE_W = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register map of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVO_ENABLED   = 3'd0,
        CFG_ISOLATION_MODE  = 3'd1,
        CFG_GRACE_MS        = 3'd2,
        CFG_OPEN_PULSE_US   = 3'd3,
        CFG_CLOSED_PULSE_US = 3'd4,
        CFG_MIN_PULSE_US    = 3'd5,
        CFG_MAX_PULSE_US    = 3'd6
    } t_cfg_index;

    typedef enum logic {
        OP_UPDATE      = 1'b0,
        OP_FORCE_CLOSE = 1'b1
    } t_operation;

    typedef enum logic [2:0] {
        REASON_NONE       = 3'd0,
        REASON_OPEN       = 3'd1,
        REASON_CMD_CLOSE  = 3'd2,
        REASON_LINK_CLOSE = 3'd3,
        REASON_FORCED     = 3'd4
    } t_reason;

    localparam logic [CMD_W-1:0] CMD_OPEN = 8'd1;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0]  GRACE_MS_RST        = 32'd200;
    localparam logic [PULSE_W-1:0] OPEN_PULSE_US_RST   = 16'd2000;
    localparam logic [PULSE_W-1:0] CLOSED_PULSE_US_RST = 16'd1000;
    localparam logic [PULSE_W-1:0] MIN_PULSE_US_RST    = 16'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_US_RST    = 16'd2500;
    // Closed pulse clamped with the reset limits
    localparam logic [PULSE_W-1:0] PULSE_RST           = 16'd1000;

    typedef struct packed {
        logic              operation;
        logic [CMD_W-1:0]  radio_cmd;
        logic              link_ok;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               pulse_written;
        logic               target_open;
        logic [2:0]         change_cause;
        logic               grace_active;
        logic [TIME_W-1:0]  grace_age_ms;
        logic [CNT_W-1:0]   update_count;
        logic [CNT_W-1:0]   change_count;
        logic [CNT_W-1:0]   grace_start_count;
        logic [CNT_W-1:0]   glitch_suppressed_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

endpackage

// ----- hdl/vslg_stream_if.sv -----
interface vslg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/vent_servo_link_loss_grace.sv -----
// Each event passes through the input register and then the result register.
// Throughput: one event per cycle while o_res is not stalled; the servo state in the result register feeds back through
//   a 32-bit age subtract and compare against grace_ms.
// While a result waits, the input register takes one more event, then the input stalls.
// Reset (i_rst_n low, synchronous): both stages empty, configuration at its defaults,
//   servo closed with the clamped closed pulse, grace idle, all counters zero.
module vent_servo_link_loss_grace
    import vslg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    vslg_stream_if.sink     i_cfg,
    vslg_stream_if.sink     i_in,
    vslg_stream_if.source   o_res
);

    // Configuration registers
    logic               r_servo_enabled;
    logic               r_isolation_mode;
    logic [TIME_W-1:0]  r_grace_ms;
    logic [PULSE_W-1:0] r_open_width;
    logic [PULSE_W-1:0] r_closed_width;
    logic [PULSE_W-1:0] r_min_width;
    logic [PULSE_W-1:0] r_max_width;

    // Input stage
    logic     r_in_valid;
    t_in_item r_in;

    // Result stage; the servo state lives in these same registers, since the
    // reported fields are exactly the state left behind by the latest event.
    logic               r_out_valid;
    logic [PULSE_W-1:0] r_pulse, n_pulse;
    logic               r_written, n_written;
    logic               r_target, n_target;
    t_reason            r_reason, n_reason;
    logic               r_grace, n_grace;
    logic [TIME_W-1:0]  r_age, n_age;
    logic [TIME_W-1:0]  r_loss_start, n_loss_start;
    logic [CNT_W-1:0]   r_updates, n_updates;
    logic [CNT_W-1:0]   r_changes, n_changes;
    logic [CNT_W-1:0]   r_grace_starts, n_grace_starts;
    logic [CNT_W-1:0]   r_glitches, n_glitches;

    logic               adv_out;
    logic               req;
    logic               link_eff;
    logic               grace_start;
    logic [TIME_W-1:0]  start_ms;
    logic [TIME_W-1:0]  age;

    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic [PULSE_W-1:0] p,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        logic [PULSE_W-1:0] res;
        // When the limits cross, values below lo give lo and all others give hi
        if (p < lo) begin
            res = lo;
        end else if (p > hi) begin
            res = hi;
        end else begin
            res = p;
        end
        return res;
    endfunction

    //--------------------------------------------------------------------
    // Configuration port: always ready, indexes beyond the map are dropped
    //--------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_enabled  <= 1'b0;
            r_isolation_mode <= 1'b0;
            r_grace_ms       <= GRACE_MS_RST;
            r_open_width     <= OPEN_PULSE_US_RST;
            r_closed_width   <= CLOSED_PULSE_US_RST;
            r_min_width      <= MIN_PULSE_US_RST;
            r_max_width      <= MAX_PULSE_US_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.payload.index))
                CFG_SERVO_ENABLED:   r_servo_enabled  <= i_cfg.payload.data[0];
                CFG_ISOLATION_MODE:  r_isolation_mode <= i_cfg.payload.data[0];
                CFG_GRACE_MS:        r_grace_ms       <= i_cfg.payload.data[TIME_W-1:0];
                CFG_OPEN_PULSE_US:   r_open_width     <= i_cfg.payload.data[PULSE_W-1:0];
                CFG_CLOSED_PULSE_US: r_closed_width   <= i_cfg.payload.data[PULSE_W-1:0];
                CFG_MIN_PULSE_US:    r_min_width      <= i_cfg.payload.data[PULSE_W-1:0];
                CFG_MAX_PULSE_US:    r_max_width      <= i_cfg.payload.data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Handshake: the result stage advances when empty or when its transfer
    // completes; the input stage refills whenever it empties into the result.
    //--------------------------------------------------------------------
    assign adv_out    = !r_out_valid || o_res.ready;
    assign i_in.ready = !r_in_valid || adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
    end

    //--------------------------------------------------------------------
    // Event processing
    //--------------------------------------------------------------------
    // Isolation forces the link low; the command only matters with the link up.
    assign link_eff    = r_in.link_ok && !r_isolation_mode;
    // Grace starts when the link is lost while the servo is open
    assign grace_start = r_target && !r_grace;
    assign start_ms    = grace_start ? r_in.now_ms : r_loss_start;
    // Wrapping elapsed time since the link was lost
    assign age         = r_in.now_ms - start_ms;

    always_comb begin
        n_pulse        = r_pulse;
        n_written      = 1'b0;
        n_target       = r_target;
        n_reason       = r_reason;
        n_grace        = r_grace;
        n_age          = r_age;
        n_loss_start   = r_loss_start;
        n_updates      = r_updates;
        n_changes      = r_changes;
        n_grace_starts = r_grace_starts;
        n_glitches     = r_glitches;
        req            = 1'b0;

        if (r_in.operation == OP_FORCE_CLOSE) begin
            if (r_servo_enabled) begin
                n_pulse   = clamp_pulse(r_closed_width, r_min_width, r_max_width);
                n_written = 1'b1;
                n_target  = 1'b0;
                n_reason  = REASON_FORCED;
                n_grace   = 1'b0;
                n_age     = '0;
            end
        end else begin
            n_updates = r_updates + CNT_W'(1);
            if (r_servo_enabled) begin
                if (r_isolation_mode) begin
                    req     = 1'b0;
                    n_grace = 1'b0;
                    n_age   = '0;
                end else if (link_eff) begin
                    // Link came back: drop the grace period, count a glitch if one ran
                    if (r_grace) begin
                        n_glitches = r_glitches + CNT_W'(1);
                    end
                    n_grace = 1'b0;
                    n_age   = '0;
                    req     = (r_in.radio_cmd == CMD_OPEN);
                end else if (grace_start || r_grace) begin
                    if (grace_start) begin
                        n_loss_start   = r_in.now_ms;
                        n_grace_starts = r_grace_starts + CNT_W'(1);
                    end
                    n_age = age;
                    // Hold open until the grace time runs out, then close
                    if (age < r_grace_ms) begin
                        req     = 1'b1;
                        n_grace = 1'b1;
                    end else begin
                        req     = 1'b0;
                        n_grace = 1'b0;
                    end
                end else begin
                    req = 1'b0;
                end

                if (req != r_target) begin
                    if (req) begin
                        n_reason = REASON_OPEN;
                        n_pulse  = clamp_pulse(r_open_width, r_min_width, r_max_width);
                    end else begin
                        n_reason = link_eff ? REASON_CMD_CLOSE : REASON_LINK_CLOSE;
                        n_pulse  = clamp_pulse(r_closed_width, r_min_width, r_max_width);
                    end
                    n_written = 1'b1;
                    n_changes = r_changes + CNT_W'(1);
                end
                n_target = req;
            end
        end
    end

    //--------------------------------------------------------------------
    // Result / state registers: load on each event leaving the input stage
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_pulse        <= PULSE_RST;
            r_written      <= 1'b0;
            r_target       <= 1'b0;
            r_reason       <= REASON_NONE;
            r_grace        <= 1'b0;
            r_age          <= '0;
            r_loss_start   <= '0;
            r_updates      <= '0;
            r_changes      <= '0;
            r_grace_starts <= '0;
            r_glitches     <= '0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_pulse        <= n_pulse;
                r_written      <= n_written;
                r_target       <= n_target;
                r_reason       <= n_reason;
                r_grace        <= n_grace;
                r_age          <= n_age;
                r_loss_start   <= n_loss_start;
                r_updates      <= n_updates;
                r_changes      <= n_changes;
                r_grace_starts <= n_grace_starts;
                r_glitches     <= n_glitches;
            end
        end
    end

    assign o_res.valid                           = r_out_valid;
    assign o_res.payload.pulse_width             = r_pulse;
    assign o_res.payload.pulse_written           = r_written;
    assign o_res.payload.target_open             = r_target;
    assign o_res.payload.change_cause            = r_reason;
    assign o_res.payload.grace_active            = r_grace;
    assign o_res.payload.grace_age_ms            = r_age;
    assign o_res.payload.update_count            = r_updates;
    assign o_res.payload.change_count            = r_changes;
    assign o_res.payload.grace_start_count       = r_grace_starts;
    assign o_res.payload.glitch_suppressed_count = r_glitches;

endmodule
